/* hw/rtl/tpsd_pkg.sv */
// Shared types and constants for the TGA pixel stream decoder.
package tpsd_pkg;

  // Image dimension and pixel-count widths
  localparam int DIM_BITS   = 15;
  localparam int TOTAL_W    = 2 * DIM_BITS;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_BITS;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RLE_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_PX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] RUN_BIAS     = 8'd127;

  // One finished pixel handed from the parser to the output side
  typedef struct packed {
    logic [23:0] assembly;   // blue 7:0, green 15:8, red 23:16
    logic [7:0]  final_byte; // red for 24-bit, alpha for 32-bit
    logic        size3;      // 24-bit pixel
    logic [7:0]  run_count;  // repeat count before clipping
    logic [7:0]  left_sat;   // pixels left in image, saturated at 255
  } pix_item_t;

endpackage

/* hw/rtl/tpsd_front.sv */
// Byte parser: configuration, packet headers, pixel assembly and pixel count.
module tpsd_front import tpsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  input  logic                  in_tuser,   // first_byte
  input  logic                  q_full,
  output logic                  push,
  output pix_item_t             push_item
);

  logic                rle_mode_r;
  logic [2:0]          bpp_r;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [TOTAL_W-1:0]  total_r;

  logic               expect_r, expect_nxt;
  logic               is_run_r, is_run_nxt;
  logic [7:0]         remain_r, remain_nxt;
  logic [1:0]         bip_r, bip_nxt;
  logic [23:0]        asm_r, asm_nxt;
  logic [TOTAL_W-1:0] done_r, done_nxt;
  logic               fin_r, fin_nxt;

  logic               acc;
  logic               e_expect, e_is_run, e_fin;
  logic [7:0]         e_remain;
  logic [1:0]         e_bip, size_m1;
  logic [23:0]        e_asm;
  logic [TOTAL_W-1:0] e_done, left, raw_ext;
  logic [TOTAL_W:0]   diff;
  logic               fin_now, size3;
  logic [7:0]         raw, cnt_clip;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  // Image size as it stands after this cycle's register write
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en && (cfg_index == CFG_IMAGE_WIDTH))  width_nxt  = cfg_wdata[DIM_BITS-1:0];
    if (cfg_wr_en && (cfg_index == CFG_IMAGE_HEIGHT)) height_nxt = cfg_wdata[DIM_BITS-1:0];
  end

  // Configuration registers and image size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_mode_r <= 1'b0;
      bpp_r      <= 3'd4;
      width_r    <= DIM_BITS'(1);
      height_r   <= DIM_BITS'(1);
      total_r    <= TOTAL_W'(1);
    end else begin
      total_r <= TOTAL_W'(width_nxt) * TOTAL_W'(height_nxt);
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_RLE_MODE:     rle_mode_r <= cfg_wdata[0];
          CFG_BYTES_PER_PX: bpp_r      <= cfg_wdata[2:0];
          CFG_IMAGE_WIDTH:  width_r    <= cfg_wdata[DIM_BITS-1:0];
          CFG_IMAGE_HEIGHT: height_r   <= cfg_wdata[DIM_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // Parser state after an optional restart on first_byte
  always_comb begin
    e_expect = in_tuser ? 1'b1 : expect_r;
    e_is_run = in_tuser ? 1'b0 : is_run_r;
    e_remain = in_tuser ? 8'd0 : remain_r;
    e_bip    = in_tuser ? 2'd0 : bip_r;
    e_asm    = in_tuser ? 24'd0 : asm_r;
    e_done   = in_tuser ? '0 : done_r;
    e_fin    = in_tuser ? 1'b0 : fin_r;
  end

  assign diff     = {1'b0, total_r} - {1'b0, e_done};
  assign fin_now  = e_fin || diff[TOTAL_W] || (diff == '0);
  assign left     = diff[TOTAL_W-1:0];
  assign size3    = (bpp_r == 3'd3);
  assign size_m1  = size3 ? 2'd2 : 2'd3;
  assign raw      = (rle_mode_r && e_is_run) ? ((e_remain != 8'd0) ? e_remain : 8'd1) : 8'd1;
  assign raw_ext  = {{(TOTAL_W-8){1'b0}}, raw};
  assign cnt_clip = (raw_ext > left) ? left[7:0] : raw;

  // Per-byte decode
  always_comb begin
    expect_nxt = expect_r;
    is_run_nxt = is_run_r;
    remain_nxt = remain_r;
    bip_nxt    = bip_r;
    asm_nxt    = asm_r;
    done_nxt   = done_r;
    fin_nxt    = fin_r;
    push       = 1'b0;
    push_item.assembly   = e_asm;
    push_item.final_byte = in_tdata;
    push_item.size3      = size3;
    push_item.run_count  = raw;
    push_item.left_sat   = (left > TOTAL_W'(255)) ? 8'hFF : left[7:0];
    if (acc) begin
      expect_nxt = e_expect;
      is_run_nxt = e_is_run;
      remain_nxt = e_remain;
      bip_nxt    = e_bip;
      asm_nxt    = e_asm;
      done_nxt   = e_done;
      fin_nxt    = e_fin;
      if (fin_now) begin
        fin_nxt = 1'b1;
      end else if (rle_mode_r && e_expect) begin
        // packet header
        is_run_nxt = in_tdata[7];
        remain_nxt = in_tdata[7] ? (in_tdata - RUN_BIAS) : (in_tdata + 8'd1);
        expect_nxt = 1'b0;
        bip_nxt    = 2'd0;
      end else if (e_bip < size_m1) begin
        // collect blue, green and, for 32-bit pixels, red
        case (e_bip)
          2'd0:    asm_nxt[7:0]   = in_tdata;
          2'd1:    asm_nxt[15:8]  = in_tdata;
          default: asm_nxt[23:16] = in_tdata;
        endcase
        bip_nxt = e_bip + 2'd1;
      end else begin
        // completing byte: one pixel out
        push    = 1'b1;
        bip_nxt = 2'd0;
        asm_nxt = 24'd0;
        if (rle_mode_r) begin
          if (e_is_run) begin
            remain_nxt = 8'd0;
            expect_nxt = 1'b1;
          end else begin
            if (e_remain != 8'd0) remain_nxt = e_remain - 8'd1;
            if (e_remain <= 8'd1) expect_nxt = 1'b1;
          end
        end
        done_nxt = e_done + {{(TOTAL_W-8){1'b0}}, cnt_clip};
        fin_nxt  = (raw_ext >= left);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 1'b1;
      is_run_r <= 1'b0;
      remain_r <= 8'd0;
      bip_r    <= 2'd0;
      asm_r    <= 24'd0;
      done_r   <= '0;
      fin_r    <= 1'b0;
    end else begin
      expect_r <= expect_nxt;
      is_run_r <= is_run_nxt;
      remain_r <= remain_nxt;
      bip_r    <= bip_nxt;
      asm_r    <= asm_nxt;
      done_r   <= done_nxt;
      fin_r    <= fin_nxt;
    end
  end

endmodule

/* hw/rtl/tpsd_queue.sv */
// Two-entry pixel queue between the parser and the output stage.
module tpsd_queue import tpsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pix_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      q_valid,
  output pix_item_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  pix_item_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]        count_r, count_nxt;
  logic                  do_push, do_pop;

  assign full    = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (PTR_W+1)'(1);
    else if (!do_push && do_pop) count_nxt = count_r - (PTR_W+1)'(1);
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_item;
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/tpsd_back.sv */
// Output stage: color formatting, count clipping, last flag and result register.
module tpsd_back import tpsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  pix_item_t  head,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [39:0] out_tdata,  // red, green, blue, alpha, repeat_count
  output logic       out_tlast    // last_pixel
);

  logic        valid_r;
  logic [39:0] data_r, data_nxt;
  logic        last_r, last_nxt;
  logic [7:0]  red, green, blue, alpha, count;

  assign pop = q_valid && (!valid_r || out_tready);

  // Pixel formatting
  always_comb begin
    blue  = head.assembly[7:0];
    green = head.assembly[15:8];
    red   = head.size3 ? head.final_byte : head.assembly[23:16];
    alpha = head.size3 ? ALPHA_OPAQUE : head.final_byte;
    count = (head.run_count > head.left_sat) ? head.left_sat : head.run_count;
    last_nxt = (head.run_count >= head.left_sat);
    data_nxt = {count, alpha, blue, green, red};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= data_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

/* hw/rtl/tga_pixel_stream_decoder_core.sv */
// TGA true-color / RLE pixel stream decoder, top level.
// Throughput: one byte transfer per cycle, back to back; in_tready drops only
// while the two-entry queue is full because the result side stalls.
// Result path: the completing byte's pixel goes to the queue, then to the output
// register, which drives out_tvalid; other bytes give no result.
// Reset (rst_n low, synchronous): config to uncompressed, 4 bytes, 1x1;
// parser awaits a packet header, counters and queue cleared, output empty.
module tga_pixel_stream_decoder_core import tpsd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // data_byte
  input  logic                  in_tuser,   // first_byte
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [39:0]           out_tdata,  // red, green, blue, alpha, repeat_count
  output logic                  out_tlast   // last_pixel
);

  pix_item_t push_item, head;
  logic      push, q_full, pop, q_valid;

  tpsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  tpsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .head      (head)
  );

  tpsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* verif/tb_tga_pixel_stream_decoder_core.sv */
// Self-checking testbench for the TGA true-color / RLE pixel stream decoder.
module tb_tga_pixel_stream_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tpsd_pkg::*;

  localparam int TARGET_BYTES   = 850;
  localparam int DRAIN_CYCLES   = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTS     = 100;
  localparam logic [CFG_DATA_W-1:0] DIM_MAX = '1;

  // One decoded pixel as seen on the result channel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] count;
    logic       last;
  } pixel_t;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

  // Directed stimulus row; typed rows carry their pixel spelled out
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [7:0]            data;
    bit                    first;
    bit                    typed;
    pixel_t                pix;
  } row_t;

  typedef struct packed {
    bit     typed;
    pixel_t pix;
  } byte_tag_t;

  typedef struct packed {
    logic [7:0] data;
    bit         first;
  } stream_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;   // data_byte
  logic                  in_tuser = 1'b0; // first_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic [39:0]           out_tdata;       // red, green, blue, alpha, repeat_count
  logic                  out_tlast;       // last_pixel

  tga_pixel_stream_decoder_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Scoreboard and run statistics
  pixel_t       expected_pixels[$];
  byte_tag_t    byte_tags[$];
  row_t         directed_rows[$];
  stream_byte_t stream_q[$];
  int           errors = 0;
  int           decoded_bytes = 0;
  int           bytes_taken = 0;
  int           pixels_checked = 0;
  int           idle_cycles = 0;
  bit           in_stall_en = 1'b1;
  bit           out_stall_en = 1'b1;

  // Decoder image: configuration copy
  bit                    mdl_rle;
  logic [2:0]            mdl_bpp;
  logic [CFG_DATA_W-1:0] mdl_w;
  logic [CFG_DATA_W-1:0] mdl_h;
  // Decoder image: parser state
  bit          hdr_due;
  bit          run_pkt;
  logic [7:0]  pkt_left;
  logic [1:0]  byte_pos;
  logic [23:0] asm_px;
  longint      px_done;
  bit          img_done;

  function automatic void restart_image();
    hdr_due  = 1'b1;
    run_pkt  = 1'b0;
    pkt_left = '0;
    byte_pos = '0;
    asm_px   = '0;
    px_done  = 0;
    img_done = 1'b0;
  endfunction

  // Expected decoder behavior for one accepted byte; returns 1 if a pixel results
  function automatic bit decode_byte(input logic [7:0] b, input bit first,
                                     output pixel_t px, output bit ignored);
    longint total, left, count;
    int     size;
    px = '0;
    ignored = 1'b0;
    if (first) restart_image();
    total = longint'(mdl_w) * longint'(mdl_h);
    if (img_done || px_done >= total) begin
      img_done = 1'b1;
      ignored = 1'b1;
      return 1'b0;
    end
    // Packet header
    if (mdl_rle && hdr_due) begin
      run_pkt  = b[7];
      pkt_left = b[7] ? 8'(b - RUN_BIAS) : 8'(b + 8'd1);
      hdr_due  = 1'b0;
      byte_pos = '0;
      return 1'b0;
    end
    size = (mdl_bpp == 3'd3) ? 3 : 4;
    if (int'(byte_pos) < size - 1) begin
      asm_px[8*byte_pos +: 8] = b;
      byte_pos = byte_pos + 2'd1;
      return 1'b0;
    end
    // Completing byte: red for 24-bit, alpha for 32-bit
    px.blue  = asm_px[7:0];
    px.green = asm_px[15:8];
    if (size == 3) begin
      px.red   = b;
      px.alpha = ALPHA_OPAQUE;
    end else begin
      px.red   = asm_px[23:16];
      px.alpha = b;
    end
    byte_pos = '0;
    asm_px   = '0;
    left  = total - px_done;
    count = 1;
    if (mdl_rle) begin
      if (run_pkt) begin
        count    = (pkt_left != 0) ? longint'(pkt_left) : 1;
        pkt_left = '0;
        hdr_due  = 1'b1;
      end else begin
        if (pkt_left != 0) pkt_left = pkt_left - 8'd1;
        if (pkt_left == 0) hdr_due = 1'b1;
      end
    end
    if (count > left) count = left;
    px_done = px_done + count;
    if (px_done >= total) img_done = 1'b1;
    px.count = 8'(count);
    px.last  = img_done;
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      note_mismatch($sformatf("pixel %0d %s got 0x%02h want 0x%02h",
                              pixels_checked, name, got, want));
  endtask

  // Transfer monitor: predicts on input transfers, checks output transfers
  always @(posedge clk) begin : monitor
    pixel_t    px;
    pixel_t    want;
    bit        has_px;
    bit        ign;
    byte_tag_t tag;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_pixels.size() == 0) begin
          note_mismatch($sformatf("pixel with none expected, tdata 0x%010h", out_tdata));
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", out_tdata[7:0], want.red);
          check_field("green", out_tdata[15:8], want.green);
          check_field("blue", out_tdata[23:16], want.blue);
          check_field("alpha", out_tdata[31:24], want.alpha);
          check_field("repeat", out_tdata[39:32], want.count);
          check_field("last", {7'd0, out_tlast}, {7'd0, want.last});
        end
        pixels_checked++;
      end
      if (in_tvalid && in_tready) begin
        tag = (byte_tags.size() != 0) ? byte_tags.pop_front() : '0;
        has_px = decode_byte(in_tdata, in_tuser, px, ign);
        if (!ign) decoded_bytes++;
        bytes_taken++;
        if (tag.typed) begin
          if (!has_px) note_mismatch("directed row expects a pixel the decoder image does not");
          expected_pixels.push_back(tag.pix);
        end else if (has_px) begin
          expected_pixels.push_back(px);
        end
      end
      // Watchdog on cycles without any transfer
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles, %0d pixels pending",
                   idle_cycles, expected_pixels.size());
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // Result-side backpressure: a random stall after each transfer
  always @(posedge clk) begin : sink
    int wait_left;
    if (out_tready) begin
      if (rst_n && out_tvalid) begin
        wait_left = out_stall_en ? $urandom_range(0, 7) : 0;
        if (wait_left > 0) out_tready <= 1'b0;
      end
    end else begin
      wait_left = wait_left - 1;
      if (wait_left <= 0) out_tready <= 1'b1;
    end
  end

  // Present one byte after a random gap and hold it until its transfer
  task automatic send_byte(input logic [7:0] d, input bit f, input bit typed, input pixel_t pix);
    int gap;
    gap = in_stall_en ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_tags.push_back('{typed, pix});
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic end_burst();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic await_results();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_RLE_MODE:     mdl_rle = val[0];
      CFG_BYTES_PER_PX: mdl_bpp = val[2:0];
      CFG_IMAGE_WIDTH:  mdl_w   = val;
      CFG_IMAGE_HEIGHT: mdl_h   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    directed_rows.push_back('{ROW_CFG, idx, val, 8'd0, 1'b0, 1'b0, pixel_t'('0)});
  endtask

  task automatic add_byte(input logic [7:0] d, input bit f);
    directed_rows.push_back('{ROW_BYTE, CFG_RLE_MODE, '0, d, f, 1'b0, pixel_t'('0)});
  endtask

  task automatic add_pixel(input logic [7:0] d, input bit f, input pixel_t pix);
    directed_rows.push_back('{ROW_BYTE, CFG_RLE_MODE, '0, d, f, 1'b1, pix});
  endtask

  task automatic push_stream(input logic [7:0] d, inout bit first_pending);
    bit f;
    f = first_pending || ($urandom_range(0, 49) == 0);
    first_pending = 1'b0;
    stream_q.push_back('{d, f});
  endtask

  // Random image data: mostly well-formed packets, some noise and broken packets
  task automatic build_stream();
    int         n;
    int         npix;
    int         size;
    int         r;
    logic [7:0] hdr;
    bit         first_pending;
    stream_q.delete();
    size = (mdl_bpp == 3'd3) ? 3 : 4;
    n = $urandom_range(8, 60);
    first_pending = ($urandom_range(0, 9) != 0);
    while (stream_q.size() < n) begin
      npix = 1;
      if (mdl_rle) begin
        r = $urandom_range(0, 9);
        if (r == 0) begin
          hdr = 8'($urandom_range(0, 255));
        end else if (r < 5) begin
          hdr = ($urandom_range(0, 9) == 0) ? 8'hFF : (8'h80 | 8'($urandom_range(0, 7)));
        end else begin
          hdr = ($urandom_range(0, 19) == 0) ? 8'h7F : 8'($urandom_range(0, 3));
        end
        npix = hdr[7] ? 1 : int'(hdr) + 1;
        push_stream(hdr, first_pending);
      end
      repeat (npix * size) push_stream(8'($urandom_range(0, 255)), first_pending);
      if ($urandom_range(0, 19) == 0) push_stream(8'($urandom_range(0, 255)), first_pending);
    end
  endtask

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] w;
    logic [CFG_DATA_W-1:0] h;
    logic [2:0]            bpp;
    bit                    rle;
    int                    phase;
    int                    pause_at;
    int                    k;

    mdl_rle = 1'b0;
    mdl_bpp = 3'd4;
    mdl_w   = 15'd1;
    mdl_h   = 15'd1;
    restart_image();

    // Reset defaults: 32-bit uncompressed 1x1, then a trailing byte past the end
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    add_pixel(8'h7F, 1'b0, '{8'h80, 8'hFF, 8'h00, 8'h7F, 8'd1, 1'b1});
    add_byte(8'h55, 1'b0);
    // 24-bit uncompressed 2x1: all-ones pixel then a plain one
    add_cfg(CFG_BYTES_PER_PX, 15'd3);
    add_cfg(CFG_IMAGE_WIDTH, 15'd2);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_pixel(8'hFF, 1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b0});
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_pixel(8'h03, 1'b0, '{8'h03, 8'h02, 8'h01, 8'hFF, 8'd1, 1'b1});
    // RLE 3x1: longest run, clipped at the image end
    add_cfg(CFG_RLE_MODE, 15'd1);
    add_cfg(CFG_IMAGE_WIDTH, 15'd3);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h10, 1'b0);
    add_byte(8'h20, 1'b0);
    add_pixel(8'h30, 1'b0, '{8'h30, 8'h20, 8'h10, 8'hFF, 8'd3, 1'b1});
    // RLE 2x1: shortest run, then a single literal
    add_cfg(CFG_IMAGE_WIDTH, 15'd2);
    add_byte(8'h80, 1'b1);
    add_byte(8'h01, 1'b0);
    add_byte(8'h02, 1'b0);
    add_byte(8'h03, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h04, 1'b0);
    add_byte(8'h05, 1'b0);
    add_byte(8'h06, 1'b0);
    // Zero height: nothing decodes
    add_cfg(CFG_IMAGE_HEIGHT, 15'd0);
    add_byte(8'hA5, 1'b1);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table walk
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        end_burst();
        await_results();
        write_reg(directed_rows[i].idx, directed_rows[i].val);
      end else begin
        send_byte(directed_rows[i].data, directed_rows[i].first,
                  directed_rows[i].typed, directed_rows[i].pix);
      end
    end
    end_burst();

    // Random phases, each with a fresh setting of every register
    phase = 0;
    while (bytes_taken < TARGET_BYTES) begin
      phase++;
      await_results();
      rle = $urandom_range(0, 1);
      bpp = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                         : (($urandom_range(0, 1) == 1) ? 3'd3 : 3'd4);
      w = 15'($urandom_range(1, 6));
      h = 15'($urandom_range(1, 4));
      if ($urandom_range(0, 19) == 0) w = DIM_MAX;
      if ($urandom_range(0, 19) == 0) h = DIM_MAX;
      if ($urandom_range(0, 29) == 0) w = '0;
      if ($urandom_range(0, 29) == 0) h = '0;
      // Force the extremes early on
      if (phase == 1) begin
        w = DIM_MAX;
        h = DIM_MAX;
        bpp = 3'd7;
      end else if (phase == 2) begin
        w = '0;
        bpp = 3'd0;
      end else if (phase == 3) begin
        rle = 1'b1;
        w = 15'd1;
        h = 15'd1;
      end
      write_reg(CFG_RLE_MODE, {14'd0, rle});
      write_reg(CFG_BYTES_PER_PX, {12'd0, bpp});
      write_reg(CFG_IMAGE_WIDTH, w);
      write_reg(CFG_IMAGE_HEIGHT, h);
      in_stall_en  = ($urandom_range(0, 3) != 0);
      out_stall_en = ($urandom_range(0, 3) != 0);
      build_stream();
      // Sometimes hold the sender until the decoder has drained
      pause_at = (phase == 4 || $urandom_range(0, 9) == 0) ? stream_q.size() / 2 : -1;
      for (k = 0; k < stream_q.size(); k++) begin
        if (k == pause_at) begin
          end_burst();
          await_results();
        end
        send_byte(stream_q[k].data, stream_q[k].first, 1'b0, pixel_t'('0));
      end
      end_burst();
    end

    await_results();
    $display("run covered %0d byte transfers (%0d decoded) over %0d random phases",
             bytes_taken, decoded_bytes, phase);
    $display("%0d pixels checked, %0d mismatches", pixels_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
